@@ design/tcw_pkg.sv @@
`timescale 1ns / 1ps

package tcw_pkg;

    // func codes on the input channel
    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // register byte address on the configuration port
    localparam logic [1:0] REG_ATTR = 2'd0;

    localparam logic [7:0] ATTR_RESET = 8'h05;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_RETURN  = 8'h0D;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] BLANK_CODE   = 8'h20;

    localparam int unsigned TAB_STEP = 8;

    typedef enum logic [2:0] {
        OP_STORE,
        OP_NEWLINE,
        OP_RETURN,
        OP_TAB,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  char_code;
        logic [10:0] cell_addr;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LIN,
        S_PHYS,
        S_WRITE,
        S_MOVE,
        S_BLANK,
        S_CLEAR,
        S_RREQ,
        S_DONE
    } t_state;

endpackage

@@ design/tcw_front.sv @@
`timescale 1ns / 1ps

module tcw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [1:0]    i_func,
    input  logic [7:0]    i_char_code,
    input  logic [10:0]   i_cell_addr,
    output logic          o_push,
    output tcw_pkg::t_cmd o_cmd,
    input  logic          i_full
);

    localparam int NCELLS = COLUMNS * ROWS;

    logic          r_valid;
    tcw_pkg::t_cmd r_cmd;
    tcw_pkg::t_cmd n_cmd;
    logic          accept;

    assign o_in_stall = r_valid && i_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_full;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_cmd.char_code = i_char_code;
        n_cmd.cell_addr = i_cell_addr;
        case (i_func)
            tcw_pkg::FUNC_PUT: begin
                case (i_char_code)
                    tcw_pkg::CHAR_NEWLINE: n_cmd.op = tcw_pkg::OP_NEWLINE;
                    tcw_pkg::CHAR_RETURN:  n_cmd.op = tcw_pkg::OP_RETURN;
                    tcw_pkg::CHAR_TAB:     n_cmd.op = tcw_pkg::OP_TAB;
                    default:               n_cmd.op = tcw_pkg::OP_STORE;
                endcase
            end
            tcw_pkg::FUNC_CLEAR: n_cmd.op = tcw_pkg::OP_CLEAR;
            tcw_pkg::FUNC_READ: begin
                // out-of-range reads report zero and touch nothing
                if (32'(i_cell_addr) < 32'(NCELLS)) begin
                    n_cmd.op = tcw_pkg::OP_READ;
                end else begin
                    n_cmd.op = tcw_pkg::OP_NOP;
                end
            end
            default: n_cmd.op = tcw_pkg::OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

@@ design/tcw_fifo.sv @@
`timescale 1ns / 1ps

module tcw_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcw_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output tcw_pkg::t_cmd o_cmd
);

    tcw_pkg::t_cmd r_slot [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

@@ design/tcw_back.sv @@
`timescale 1ns / 1ps

module tcw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_attr,
    input  logic          i_q_valid,
    input  tcw_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [15:0]   o_cell_data,
    output logic [6:0]    o_cursor_col,
    output logic [4:0]    o_cursor_row
);

    localparam int NCELLS = COLUMNS * ROWS;
    localparam int AW     = $clog2(NCELLS);
    localparam int XW     = $clog2(COLUMNS);
    localparam int YW     = $clog2(ROWS);

    localparam logic [AW:0] NC_W  = (AW+1)'(NCELLS);
    localparam logic [AW:0] COL_W = (AW+1)'(COLUMNS);

    tcw_pkg::t_state r_state;
    tcw_pkg::t_state n_state;

    logic [15:0]   r_mem [NCELLS];
    logic [15:0]   r_rd;

    tcw_pkg::t_cmd r_cmd;
    logic [AW-1:0] r_lin;
    logic [AW-1:0] r_phys;
    logic [XW-1:0] r_cnt;
    logic [XW-1:0] r_cur_x;
    logic [YW-1:0] r_cur_y;
    logic [AW-1:0] r_base;
    logic          r_blank_go;
    logic          r_out_valid;
    logic [15:0]   r_cell_data;
    logic [6:0]    r_col;
    logic [4:0]    r_row;

    logic          mem_we;
    logic [15:0]   mem_wdata;
    logic          out_load;

    logic [AW-1:0] lin_next;
    logic [AW:0]   phys_sum;
    logic [AW-1:0] phys_next;
    logic [AW:0]   base_sum;
    logic [AW-1:0] base_next;
    logic [XW:0]   x_inc;
    logic [XW:0]   x_tab;
    logic [XW:0]   x1;
    logic          wrap;
    logic          at_bottom;
    logic          blank_end;
    logic          clear_end;

    // datapath terms
    always_comb begin
        if (r_cmd.op == tcw_pkg::OP_READ) begin
            lin_next = AW'(r_cmd.cell_addr);
        end else begin
            lin_next = AW'(32'(r_cur_y) * 32'(COLUMNS) + 32'(r_cur_x));
        end

        // rows live in a ring: logical cell plus row base, modulo the store size
        phys_sum  = {1'b0, r_lin} + {1'b0, r_base};
        phys_next = (phys_sum >= NC_W) ? AW'(phys_sum - NC_W) : AW'(phys_sum);

        base_sum  = {1'b0, r_base} + COL_W;
        base_next = (base_sum >= NC_W) ? AW'(base_sum - NC_W) : AW'(base_sum);

        x_inc = {1'b0, r_cur_x} + (XW+1)'(1);
        x_tab = ({1'b0, r_cur_x} + (XW+1)'(tcw_pkg::TAB_STEP))
              & ~((XW+1)'(tcw_pkg::TAB_STEP - 1));
        case (r_cmd.op)
            tcw_pkg::OP_STORE: x1 = x_inc;
            tcw_pkg::OP_TAB:   x1 = x_tab;
            default:           x1 = '0;
        endcase
        wrap      = (r_cmd.op == tcw_pkg::OP_NEWLINE) || (x1 >= (XW+1)'(COLUMNS));
        at_bottom = (r_cur_y == YW'(ROWS - 1));
        blank_end = (r_cnt == XW'(COLUMNS - 1));
        clear_end = (r_phys == AW'(NCELLS - 1));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tcw_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_cmd.op)
                        tcw_pkg::OP_CLEAR:   n_state = tcw_pkg::S_CLEAR;
                        tcw_pkg::OP_READ:    n_state = tcw_pkg::S_LIN;
                        tcw_pkg::OP_STORE:   n_state = tcw_pkg::S_LIN;
                        tcw_pkg::OP_NEWLINE: n_state = tcw_pkg::S_MOVE;
                        tcw_pkg::OP_RETURN:  n_state = tcw_pkg::S_MOVE;
                        tcw_pkg::OP_TAB:     n_state = tcw_pkg::S_MOVE;
                        default:             n_state = tcw_pkg::S_DONE;
                    endcase
                end
            end
            tcw_pkg::S_LIN: n_state = tcw_pkg::S_PHYS;
            tcw_pkg::S_PHYS: begin
                if (r_blank_go) begin
                    n_state = tcw_pkg::S_BLANK;
                end else if (r_cmd.op == tcw_pkg::OP_READ) begin
                    n_state = tcw_pkg::S_RREQ;
                end else begin
                    n_state = tcw_pkg::S_WRITE;
                end
            end
            tcw_pkg::S_WRITE: n_state = tcw_pkg::S_MOVE;
            tcw_pkg::S_MOVE:  n_state = wrap ? tcw_pkg::S_LIN : tcw_pkg::S_DONE;
            tcw_pkg::S_BLANK: n_state = blank_end ? tcw_pkg::S_DONE : tcw_pkg::S_BLANK;
            tcw_pkg::S_CLEAR: n_state = clear_end ? tcw_pkg::S_DONE : tcw_pkg::S_CLEAR;
            tcw_pkg::S_RREQ:  n_state = tcw_pkg::S_DONE;
            tcw_pkg::S_DONE:  n_state = out_load ? tcw_pkg::S_IDLE : tcw_pkg::S_DONE;
            default:          n_state = tcw_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_q_pop   = (r_state == tcw_pkg::S_IDLE) && i_q_valid;
        out_load  = (r_state == tcw_pkg::S_DONE) && (!r_out_valid || !i_out_stall);
        mem_we    = (r_state == tcw_pkg::S_WRITE) || (r_state == tcw_pkg::S_BLANK)
                 || (r_state == tcw_pkg::S_CLEAR);
        mem_wdata = (r_state == tcw_pkg::S_WRITE) ? {i_attr, r_cmd.char_code}
                                                  : {i_attr, tcw_pkg::BLANK_CODE};
    end

    // cell store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_phys] <= mem_wdata;
        end
        if (r_state == tcw_pkg::S_RREQ) begin
            r_rd <= r_mem[r_phys];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::S_IDLE;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_base      <= '0;
            r_blank_go  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_q_pop) begin
                r_blank_go <= 1'b0;
            end
            if (r_state == tcw_pkg::S_MOVE) begin
                r_blank_go <= wrap;
                if (wrap) begin
                    r_cur_x <= '0;
                    if (at_bottom) begin
                        // scroll: advance the ring base, cursor stays on the last row
                        r_base <= base_next;
                    end else begin
                        r_cur_y <= r_cur_y + YW'(1);
                    end
                end else begin
                    r_cur_x <= x1[XW-1:0];
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            tcw_pkg::S_IDLE: begin
                if (o_q_pop) begin
                    r_cmd  <= i_q_cmd;
                    r_phys <= '0;
                end
            end
            tcw_pkg::S_LIN: r_lin <= lin_next;
            tcw_pkg::S_PHYS: begin
                r_phys <= phys_next;
                r_cnt  <= '0;
            end
            tcw_pkg::S_BLANK, tcw_pkg::S_CLEAR: begin
                r_phys <= r_phys + AW'(1);
                r_cnt  <= r_cnt + XW'(1);
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_cell_data <= (r_cmd.op == tcw_pkg::OP_READ) ? r_rd : 16'h0000;
            r_col       <= 7'(r_cur_x);
            r_row       <= 5'(r_cur_y);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_data  = r_cell_data;
    assign o_cursor_col = r_col;
    assign o_cursor_row = r_row;

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cur_x) < 32'(COLUMNS)) && (32'(r_cur_y) < 32'(ROWS)))
        else $error("cursor outside the screen");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid && (r_state == tcw_pkg::S_IDLE))
        else $error("result load did not present a result");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state != tcw_pkg::S_IDLE))
        else $error("queue popped without leaving idle");

    a_blank_after_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcw_pkg::S_MOVE && wrap) |=> r_blank_go && (r_cur_x == '0))
        else $error("row wrap without a pending row blank");

endmodule

@@ design/text_console_writer.sv @@
`timescale 1ns / 1ps
// The execution unit takes one item at a time; the single write port of the cell store
//   sets the cost of row blanking and screen clear, which write the cells in a sweep.
// Scroll moves a row base pointer, so it costs no copy. Reset (synchronous, active low)
//   homes the cursor, sets attribute to 5 and empties the queue; the cell store is not cleared.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_addr,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_cell_data,
    output logic [6:0]  o_cursor_col,
    output logic [4:0]  o_cursor_row
);

    logic [7:0]    r_attr;
    logic          push;
    logic          full;
    logic          pop;
    logic          q_valid;
    tcw_pkg::t_cmd front_cmd;
    tcw_pkg::t_cmd q_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr == tcw_pkg::REG_ATTR) ? {24'h000000, r_attr} : 32'h00000000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcw_pkg::ATTR_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == tcw_pkg::REG_ATTR)) begin
            r_attr <= pwdata[7:0];
        end
    end

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_char_code (i_char_code),
        .i_cell_addr (i_cell_addr),
        .o_push      (push),
        .o_cmd       (front_cmd),
        .i_full      (full)
    );

    tcw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_attr       (r_attr),
        .i_q_valid    (q_valid),
        .i_q_cmd      (q_cmd),
        .o_q_pop      (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cell_data  (o_cell_data),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row)
    );

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int COLUMNS = 80;
    localparam int ROWS = 25;
    localparam int NCELLS = COLUMNS * ROWS;
    localparam int ADDR_MAX = 2047;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int TAIL_CYCLES = 50;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int PHASES = 4;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [6:0]  col;
        logic [4:0]  row;
    } t_cell_report;

    typedef struct packed {
        logic [1:0]   func;
        logic [7:0]   char_code;
        logic [10:0]  cell_addr;
        logic         typed;
        t_cell_report result;
    } t_opening_op;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = tcw_pkg::REG_ATTR;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_func = tcw_pkg::FUNC_PUT;
    logic [7:0]  i_char_code = '0;
    logic [10:0] i_cell_addr = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_cell_data;
    logic [6:0]  o_cursor_col;
    logic [4:0]  o_cursor_row;

    text_console_writer #(
        .COLUMNS(COLUMNS),
        .ROWS(ROWS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_func(i_func),
        .i_char_code(i_char_code),
        .i_cell_addr(i_cell_addr),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_cell_data(o_cell_data),
        .o_cursor_col(o_cursor_col),
        .o_cursor_row(o_cursor_row)
    );

    always #10 i_clk = ~i_clk;

    // console state as the block should hold it
    logic [15:0] screen [0:NCELLS-1];
    int unsigned cur_col = 0;
    int unsigned cur_row = 0;
    logic [7:0]  console_attr = tcw_pkg::ATTR_RESET;

    t_cell_report pending_results[$];
    t_opening_op  opening_script[$];

    int error_count = 0;
    int cycle_count = 0;
    int transfer_count = 0;
    int put_count = 0;
    int read_count = 0;
    int clear_count = 0;
    int scroll_count = 0;
    int attr_writes = 0;
    int sink_hold_cycles = 0;
    int burst_left = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    function automatic void blank_screen_row(int unsigned r);
        int unsigned c;
        for (c = 0; c < COLUMNS; c++) begin
            screen[r * COLUMNS + c] = {console_attr, tcw_pkg::BLANK_CODE};
        end
    endfunction

    function automatic t_cell_report apply_console_op(logic [1:0] f, logic [7:0] ch,
                                                      logic [10:0] addr);
        t_cell_report r;
        int unsigned x;
        int unsigned y;
        int unsigned i;
        bit wipe;
        r.cell_data = '0;
        if (f == tcw_pkg::FUNC_PUT) begin
            x = cur_col;
            y = cur_row;
            wipe = 1'b0;
            put_count++;
            if (ch == tcw_pkg::CHAR_NEWLINE) begin
                x = 0;
                y++;
                wipe = 1'b1;
            end else if (ch == tcw_pkg::CHAR_RETURN) begin
                x = 0;
            end else if (ch == tcw_pkg::CHAR_TAB) begin
                x = (x + tcw_pkg::TAB_STEP) & ~(tcw_pkg::TAB_STEP - 1);
            end else begin
                screen[y * COLUMNS + x] = {console_attr, ch};
                x++;
            end
            if (x >= COLUMNS) begin
                x = 0;
                y++;
                wipe = 1'b1;
            end
            if (y >= ROWS) begin
                y = ROWS - 1;
                scroll_count++;
                for (i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
                    screen[i] = screen[i + COLUMNS];
                end
            end
            if (wipe) begin
                blank_screen_row(y);
            end
            cur_col = x;
            cur_row = y;
        end else if (f == tcw_pkg::FUNC_CLEAR) begin
            clear_count++;
            for (i = 0; i < NCELLS; i++) begin
                screen[i] = {console_attr, tcw_pkg::BLANK_CODE};
            end
        end else if (f == tcw_pkg::FUNC_READ) begin
            read_count++;
            if (addr < NCELLS) begin
                r.cell_data = screen[addr];
            end
        end
        r.col = cur_col[6:0];
        r.row = cur_row[4:0];
        return r;
    endfunction

    // Offer one operation; predict it at the edge that takes the transfer.
    task automatic send_op(input logic [1:0] f, input logic [7:0] ch, input logic [10:0] addr,
                           input bit typed, input t_cell_report typed_result);
        int gap;
        t_cell_report r;
        if ($urandom_range(0, 24) == 0) begin
            tx_calm = !tx_calm;
        end
        gap = (tx_calm || burst_left > 0) ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= f;
        i_char_code <= ch;
        i_cell_addr <= addr;
        do @(posedge i_clk); while (o_in_stall);
        r = apply_console_op(f, ch, addr);
        pending_results.push_back(typed ? typed_result : r);
        transfer_count++;
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_access(input bit wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= tcw_pkg::REG_ATTR;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Write the attribute register and read it back.
    task automatic set_attribute(input logic [7:0] value);
        logic [31:0] rd;
        apb_access(1'b1, {24'($urandom_range(0, 32'hFF_FFFF)), value}, rd);
        console_attr = value;
        attr_writes++;
        @(posedge i_clk);
        apb_access(1'b0, '0, rd);
        if (rd[7:0] !== value) begin
            error_count++;
            if (error_count <= 10) begin
                $display("attribute readback: expected %02h, got %02h", value, rd[7:0]);
            end
        end
    endtask

    task automatic add_op(input logic [1:0] f, input logic [7:0] ch, input logic [10:0] addr,
                          input bit typed, input logic [15:0] data, input logic [6:0] col,
                          input logic [4:0] row);
        opening_script.push_back({f, ch, addr, typed, data, col, row});
    endtask

    task automatic send_random_op();
        int pick;
        logic [10:0] addr;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            send_op(tcw_pkg::FUNC_PUT, 8'($urandom_range(0, 255)),
                    11'($urandom_range(0, ADDR_MAX)), 1'b0, '0);
        end else if (pick < 67) begin
            send_op(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_NEWLINE, '0, 1'b0, '0);
        end else if (pick < 73) begin
            send_op(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_TAB, '0, 1'b0, '0);
        end else if (pick < 77) begin
            send_op(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_RETURN, '0, 1'b0, '0);
        end else if (pick < 97) begin
            if ($urandom_range(0, 9) == 0) begin
                addr = 11'($urandom_range(NCELLS, ADDR_MAX));
            end else if ($urandom_range(0, 1) == 0) begin
                // aim at the row under the cursor, where most writes land
                addr = 11'(cur_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
            end else begin
                addr = 11'($urandom_range(0, NCELLS - 1));
            end
            send_op(tcw_pkg::FUNC_READ, 8'($urandom_range(0, 255)), addr, 1'b0, '0);
        end else if (pick < 98) begin
            send_op(tcw_pkg::FUNC_CLEAR, 8'($urandom_range(0, 255)),
                    11'($urandom_range(0, ADDR_MAX)), 1'b0, '0);
        end else begin
            send_op(FUNC_UNUSED, 8'($urandom_range(0, 255)), 11'($urandom_range(0, ADDR_MAX)),
                    1'b0, '0);
        end
    endtask

    // result side: random stalls, with one long hold-off on request
    initial begin : result_sink
        int k;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 24) == 0) begin
                rx_calm = !rx_calm;
            end
            k = rx_calm ? 0 : $urandom_range(0, 12);
            if (sink_hold_cycles != 0) begin
                k = sink_hold_cycles;
                sink_hold_cycles = 0;
            end
            if (k > 0) begin
                i_out_stall <= 1'b1;
                repeat (k) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        t_cell_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("unexpected result: data %04h col %0d row %0d",
                             o_cell_data, o_cursor_col, o_cursor_row);
                end
            end else begin
                want = pending_results.pop_front();
                if (o_cell_data !== want.cell_data || o_cursor_col !== want.col ||
                    o_cursor_row !== want.row) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("mismatch: expected data %04h col %0d row %0d, got %04h %0d %0d",
                                 want.cell_data, want.col, want.row,
                                 o_cell_data, o_cursor_col, o_cursor_row);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        int i;
        int phase;
        logic [7:0] attr_value;
        t_opening_op op;
        for (i = 0; i < NCELLS; i++) begin
            screen[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // home cursor, store, unused code, then clear so every later read is defined
        add_op(tcw_pkg::FUNC_PUT, 8'h41, 11'd0, 1'b1, 16'h0000, 7'd1, 5'd0);
        add_op(tcw_pkg::FUNC_READ, 8'h00, 11'd0, 1'b1, 16'h0541, 7'd1, 5'd0);
        add_op(FUNC_UNUSED, 8'hFF, 11'd2047, 1'b1, 16'h0000, 7'd1, 5'd0);
        add_op(tcw_pkg::FUNC_CLEAR, 8'h00, 11'd0, 1'b1, 16'h0000, 7'd1, 5'd0);
        add_op(tcw_pkg::FUNC_READ, 8'h00, 11'd1999, 1'b1, 16'h0520, 7'd1, 5'd0);
        add_op(tcw_pkg::FUNC_READ, 8'h00, 11'd2000, 1'b1, 16'h0000, 7'd1, 5'd0);
        add_op(tcw_pkg::FUNC_READ, 8'hFF, 11'd2047, 1'b1, 16'h0000, 7'd1, 5'd0);
        add_op(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_TAB, 11'd0, 1'b1, 16'h0000, 7'd8, 5'd0);
        add_op(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_RETURN, 11'd0, 1'b1, 16'h0000, 7'd0, 5'd0);
        add_op(tcw_pkg::FUNC_PUT, 8'hFF, 11'd0, 1'b1, 16'h0000, 7'd1, 5'd0);
        add_op(tcw_pkg::FUNC_PUT, 8'h00, 11'd0, 1'b1, 16'h0000, 7'd2, 5'd0);
        add_op(tcw_pkg::FUNC_READ, 8'h00, 11'd1, 1'b1, 16'h0500, 7'd2, 5'd0);
        add_op(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_NEWLINE, 11'd0, 1'b1, 16'h0000, 7'd0, 5'd1);
        add_op(tcw_pkg::FUNC_READ, 8'h00, 11'd80, 1'b1, 16'h0520, 7'd0, 5'd1);
        // tabs across the row; the last stop lands past the end and wraps
        for (i = 0; i < 10; i++) begin
            add_op(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_TAB, 11'd0, 1'b0, '0, '0, '0);
        end
        add_op(tcw_pkg::FUNC_READ, 8'h00, 11'd160, 1'b0, '0, '0, '0);

        for (i = 0; i < opening_script.size(); i++) begin
            op = opening_script[i];
            send_op(op.func, op.char_code, op.cell_addr, op.typed, op.result);
        end
        wait_results_drained();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: attr_value = 8'hFF;
                1: attr_value = 8'h00;
                default: attr_value = 8'($urandom_range(0, 255));
            endcase
            set_attribute(attr_value);
            if (phase == 1) begin
                // stall the result side long enough to back up the input side
                sink_hold_cycles = 600;
                burst_left = 40;
            end
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                send_random_op();
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (phase == 2 && i == ITEMS_PER_PHASE / 2) begin
                    wait_results_drained();
                end
            end
            wait_results_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        error_count += pending_results.size();
        $display("Covered %0d transfers: %0d puts, %0d reads, %0d clears, %0d scrolls",
                 transfer_count, put_count, read_count, clear_count, scroll_count);
        $display("Attribute written %0d times, 0x00 and 0xFF among them; %0d errors",
                 attr_writes, error_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/tcw_pkg.sv
design/tcw_front.sv
design/tcw_fifo.sv
design/tcw_back.sv
design/text_console_writer.sv
bench/tb.sv
